>>> rtl/ncd_pkg.sv
// ncd_pkg: shared types and constants for the negative cycle detector.
// Used by ncd_ctrl, ncd_dpath and negative_cycle_detector. No dependencies.
package ncd_pkg;

  localparam int DEF_MAX_NODES  = 256;
  localparam int DEF_MAX_EDGES  = 4096;
  localparam int DEF_COST_WIDTH = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic signed [63:0] DIST_SENTINEL = 64'sd1000000000000000000;
  localparam logic signed [63:0] DIST_MAX      = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] DIST_MIN      = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic init_start;
    logic init_step;
    logic pass_start;
    logic edge_rd;
    logic dist_rd;
    logic sum;
    logic cmp;
    logic edge_next;
    logic pass_next;
    logic result_load;
  } ncd_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic init_last;
    logic total_zero;
    logic skip;
    logic edge_last;
    logic pass_last;
    logic out_busy;
  } ncd_stat_t;

endpackage

>>> rtl/ncd_dpath.sv
// ncd_dpath: edge store, distance store, counters, relaxation arithmetic
// and result register. Depends on ncd_pkg; driven by ncd_ctrl.
module ncd_dpath import ncd_pkg::*; #(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_EDGES  = DEF_MAX_EDGES,
  parameter int COST_WIDTH = DEF_COST_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [8:0]                   cfg_wdata,
  input  logic                         in_fire,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   edge_from,
  input  logic [7:0]                   edge_to,
  input  logic signed [COST_WIDTH-1:0] edge_cost,
  input  ncd_cmd_t                     ctl,
  output ncd_stat_t                    stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         negative_cycle,
  output logic                         edges_dropped
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 16 + COST_WIDTH;

  logic [8:0]      node_count;
  logic [8:0]      n_eff;
  logic [ECW-1:0]  edge_total;
  logic            overflow_seen;
  logic            pass_relaxed;
  logic [ECW-1:0]  edge_idx;
  logic [8:0]      pass_idx;
  logic [8:0]      init_idx;

  logic [EW-1:0]   edge_mem [MAX_EDGES];
  logic [EW-1:0]   edge_q;
  logic signed [63:0] dist_mem [MAX_NODES];
  logic signed [63:0] dfrom_q;
  logic signed [63:0] dto_q;
  logic signed [63:0] cand;
  logic signed [63:0] cand_next;
  logic signed [64:0] sum_w;

  logic [7:0]                   e_from;
  logic [7:0]                   e_to;
  logic signed [COST_WIDTH-1:0] e_cost;
  logic                         append_we;
  logic                         better;
  logic                         dist_we;
  logic [NAW-1:0]               dist_waddr;
  logic signed [63:0]           dist_wdata;

  assign e_from = edge_q[EW-1 -: 8];
  assign e_to   = edge_q[EW-9 -: 8];
  assign e_cost = signed'(edge_q[COST_WIDTH-1:0]);

  always_comb begin
    if (32'(node_count) > MAX_NODES) begin
      n_eff = 9'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign append_we = in_fire && (cmd == CMD_APPEND) && (edge_total < ECW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 9'd1;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total    <= '0;
      overflow_seen <= 1'b0;
    end else if (in_fire && cmd == CMD_CLEAR) begin
      edge_total    <= '0;
      overflow_seen <= 1'b0;
    end else if (in_fire && cmd == CMD_APPEND) begin
      if (append_we) begin
        edge_total <= edge_total + ECW'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // edge store
  always_ff @(posedge clk) begin
    if (append_we) begin
      edge_mem[edge_total[EAW-1:0]] <= {edge_from, edge_to, edge_cost};
    end
    if (ctl.edge_rd) begin
      edge_q <= edge_mem[edge_idx[EAW-1:0]];
    end
  end

  // distance store, one write port, two read ports
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = NAW'(e_to);
    dist_wdata = cand;
    if (ctl.init_step) begin
      dist_we    = 1'b1;
      dist_waddr = NAW'(init_idx);
      dist_wdata = (init_idx == 9'd0) ? 64'sd0 : DIST_SENTINEL;
    end else if (ctl.cmp && better) begin
      dist_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (ctl.dist_rd) begin
      dfrom_q <= dist_mem[NAW'(e_from)];
      dto_q   <= dist_mem[NAW'(e_to)];
    end
  end

  // saturating add of distance and cost
  assign sum_w = {dfrom_q[63], dfrom_q}
               + {{(65 - COST_WIDTH){e_cost[COST_WIDTH-1]}}, e_cost};

  always_comb begin
    if (sum_w[64] != sum_w[63]) begin
      cand_next = sum_w[64] ? DIST_MIN : DIST_MAX;
    end else begin
      cand_next = sum_w[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      cand <= cand_next;
    end
  end

  assign better = dto_q > cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx     <= '0;
      pass_idx     <= '0;
      edge_idx     <= '0;
      pass_relaxed <= 1'b0;
    end else begin
      if (ctl.init_start) begin
        init_idx     <= '0;
        pass_idx     <= '0;
        pass_relaxed <= 1'b0;
      end
      if (ctl.init_step) begin
        init_idx <= init_idx + 9'd1;
      end
      if (ctl.pass_start) begin
        edge_idx     <= '0;
        pass_relaxed <= 1'b0;
      end
      if (ctl.edge_next) begin
        edge_idx <= edge_idx + ECW'(1);
      end
      if (ctl.pass_next) begin
        pass_idx <= pass_idx + 9'd1;
      end
      if (ctl.cmp && better) begin
        pass_relaxed <= 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      negative_cycle <= pass_relaxed;
      edges_dropped  <= overflow_seen;
    end
  end

  assign stat.n_zero     = (n_eff == 9'd0);
  assign stat.init_last  = (init_idx == n_eff - 9'd1);
  assign stat.total_zero = (edge_total == '0);
  assign stat.skip       = ({1'b0, e_from} >= n_eff) || ({1'b0, e_to} >= n_eff);
  assign stat.edge_last  = (edge_idx == edge_total - ECW'(1));
  assign stat.pass_last  = (pass_idx == n_eff - 9'd1);
  assign stat.out_busy   = out_valid;

endmodule

>>> rtl/ncd_ctrl.sv
// ncd_ctrl: sequencing state machine for init sweep, passes and edges.
// Depends on ncd_pkg; drives ncd_dpath.
module ncd_ctrl import ncd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] cmd,
  output logic      in_ready,
  input  ncd_stat_t stat,
  output ncd_cmd_t  ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_PSTRT = 4'd2;
  localparam logic [3:0] S_ERD   = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;
  localparam logic [3:0] S_DSUM  = 4'd5;
  localparam logic [3:0] S_DCMP  = 4'd6;
  localparam logic [3:0] S_PEND  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = (cmd != CMD_RUN) || !stat.out_busy;
        if (in_valid && in_ready && cmd == CMD_RUN) begin
          ctl.init_start = 1'b1;
          state_next     = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.n_zero) begin
          state_next = S_DONE;
        end else begin
          ctl.init_step = 1'b1;
          if (stat.init_last) begin
            state_next = S_PSTRT;
          end
        end
      end
      S_PSTRT: begin
        ctl.pass_start = 1'b1;
        state_next     = stat.total_zero ? S_PEND : S_ERD;
      end
      S_ERD: begin
        ctl.edge_rd = 1'b1;
        state_next  = S_DRD;
      end
      S_DRD: begin
        if (stat.skip) begin
          if (stat.edge_last) begin
            state_next = S_PEND;
          end else begin
            ctl.edge_next = 1'b1;
            state_next    = S_ERD;
          end
        end else begin
          ctl.dist_rd = 1'b1;
          state_next  = S_DSUM;
        end
      end
      S_DSUM: begin
        ctl.sum    = 1'b1;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        ctl.cmp = 1'b1;
        if (stat.edge_last) begin
          state_next = S_PEND;
        end else begin
          ctl.edge_next = 1'b1;
          state_next    = S_ERD;
        end
      end
      S_PEND: begin
        if (stat.pass_last) begin
          state_next = S_DONE;
        end else begin
          ctl.pass_next = 1'b1;
          state_next    = S_PSTRT;
        end
      end
      S_DONE: begin
        ctl.result_load = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/negative_cycle_detector.sv
// negative_cycle_detector: top level, edge loader and Bellman-Ford run.
// Depends on ncd_pkg, ncd_ctrl and ncd_dpath.
//
//  channel  handshake             word
//  in       in_valid / in_ready   cmd, edge_from, edge_to, edge_cost
//  out      out_valid / out_ready negative_cycle, edges_dropped
//  cfg      cfg_we                cfg_wdata (node_count)
//
// Clear and append words are accepted one per cycle while idle.
// A run sweeps the N node distances, then makes N passes over the E stored edges
// (when N is 0 it goes straight to the result); each edge is read, then both
// distances are read, added, compared and written, in turn over the single-ported
// edge read; an edge with an endpoint out of range skips all after its reads.
// The result sits in an output register; loads go on while it waits, a new
// run waits until it is taken. rst is synchronous and clears all control.
module negative_cycle_detector import ncd_pkg::*; #(
  parameter int MAX_NODES  = DEF_MAX_NODES,
  parameter int MAX_EDGES  = DEF_MAX_EDGES,
  parameter int COST_WIDTH = DEF_COST_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [8:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   edge_from,
  input  logic [7:0]                   edge_to,
  input  logic signed [COST_WIDTH-1:0] edge_cost,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         negative_cycle,
  output logic                         edges_dropped
);

  ncd_cmd_t  ctl;
  ncd_stat_t stat;
  logic      in_fire;

  assign in_fire = in_valid && in_ready;

  ncd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ncd_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .COST_WIDTH (COST_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_fire        (in_fire),
    .cmd            (cmd),
    .edge_from      (edge_from),
    .edge_to        (edge_to),
    .edge_cost      (edge_cost),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .negative_cycle (negative_cycle),
    .edges_dropped  (edges_dropped)
  );

endmodule

>>> tb/tb.sv
// tb: self-checking bench for negative_cycle_detector (edge loader plus Bellman-Ford run).
// Depends on ncd_pkg and the negative_cycle_detector RTL; a shadow graph predicts each run.
`timescale 1ns / 1ps

module tb import ncd_pkg::*; ();

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT       = 1_500_000;
  localparam int HOLD_AT     = 20;
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE      = 16;

  typedef struct {
    logic neg;
    logic drop;
  } verdict_t;

  class graph_shadow;
    bit [7:0] tail_node [DEF_MAX_EDGES];
    bit [7:0] head_node [DEF_MAX_EDGES];
    longint   weight    [DEF_MAX_EDGES];
    int       stored;
    bit       overflowed;
    bit [8:0] nodes;
    verdict_t verdict_q [$];
    int       errors;
    int       words;
    int       runs;

    function new();
      stored     = 0;
      overflowed = 1'b0;
      nodes      = 9'd1;
      errors     = 0;
      words      = 0;
      runs       = 0;
    endfunction

    function void set_nodes(bit [8:0] v);
      nodes = v;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = a + b;
      if (s > DIST_MAX) return DIST_MAX;
      if (s < DIST_MIN) return DIST_MIN;
      return s[63:0];
    endfunction

    // true when the last of n passes still lowered a distance
    function bit relax_verdict();
      longint best [DEF_MAX_NODES];
      longint cand;
      int     n;
      bit     relaxed;
      n = (nodes > DEF_MAX_NODES) ? DEF_MAX_NODES : nodes;
      foreach (best[i]) best[i] = DIST_SENTINEL;
      best[0] = 0;
      relaxed = 1'b0;
      for (int p = 0; p < n; p++) begin
        relaxed = 1'b0;
        for (int e = 0; e < stored; e++) begin
          if (tail_node[e] >= n || head_node[e] >= n) continue;
          cand = sat_sum(best[tail_node[e]], weight[e]);
          if (best[head_node[e]] > cand) begin
            best[head_node[e]] = cand;
            relaxed = 1'b1;
          end
        end
      end
      return relaxed;
    endfunction

    function void note_word(logic [1:0] c, logic [7:0] f, logic [7:0] t,
                            logic signed [31:0] w);
      verdict_t v;
      words++;
      case (c)
        CMD_CLEAR: begin
          stored     = 0;
          overflowed = 1'b0;
        end
        CMD_APPEND: begin
          if (stored >= DEF_MAX_EDGES) begin
            overflowed = 1'b1;
          end else begin
            tail_node[stored] = f;
            head_node[stored] = t;
            weight[stored]    = longint'(w);
            stored++;
          end
        end
        CMD_RUN: begin
          v.neg  = relax_verdict();
          v.drop = overflowed;
          verdict_q = {verdict_q, v};
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic neg, logic drop);
      verdict_t v;
      runs++;
      if (verdict_q.size() == 0) begin
        $error("result with no run pending: negative_cycle %0b edges_dropped %0b", neg, drop);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (neg !== v.neg) begin
        $error("negative_cycle: expected %0b, got %0b", v.neg, neg);
        errors++;
      end
      if (drop !== v.drop) begin
        $error("edges_dropped: expected %0b, got %0b", v.drop, drop);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [8:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd;
  logic [7:0]         edge_from;
  logic [7:0]         edge_to;
  logic signed [31:0] edge_cost;
  logic               out_valid;
  logic               out_ready;
  logic               negative_cycle;
  logic               edges_dropped;

  graph_shadow shadow = new();
  bit          burst = 1'b0;
  int unsigned cycles = 0;

  negative_cycle_detector i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .edge_from      (edge_from),
    .edge_to        (edge_to),
    .edge_cost      (edge_cost),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .negative_cycle (negative_cycle),
    .edges_dropped  (edges_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) shadow.note_word(cmd, edge_from, edge_to, edge_cost);
    if (!rst && out_valid && out_ready) shadow.check_verdict(negative_cycle, edges_dropped);
  end

  task automatic send_word(logic [1:0] c, logic [7:0] f, logic [7:0] t, logic [31:0] w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    edge_from <= f;
    edge_to   <= t;
    edge_cost <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [1:0] c);
    send_word(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom);
  endtask

  // node_count only moves once the block has drained
  task automatic set_node_count(logic [8:0] v);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    shadow.set_nodes(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'(int'($urandom_range(0, 26)) - 6);
    if (r < 80) return $urandom;
    if (r < 85) return 32'h7fff_ffff;
    if (r < 90) return 32'h8000_0000;
    return 32'(int'($urandom_range(0, 2)) - 1);
  endfunction

  function automatic logic [7:0] pick_node(int n);
    if (n > 0 && $urandom_range(0, 99) < 85)
      return 8'($urandom_range(0, ((n > DEF_MAX_NODES) ? DEF_MAX_NODES : n) - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // clear / append a few / run, with stray clears, unused words and skipped runs
  task automatic random_phase(int n, int count);
    int issued;
    int loaded;
    int cap;
    int k;
    cap    = (n > 16) ? 4 : 24;
    issued = 1;
    loaded = 0;
    burst  = ($urandom_range(0, 3) == 0);
    send_cmd(CMD_CLEAR);
    while (issued < count) begin
      if ($urandom_range(0, 99) < 15 || loaded >= cap) begin
        send_cmd(CMD_CLEAR);
        loaded = 0;
        issued++;
      end
      k = $urandom_range(0, (cap - loaded < 8) ? cap - loaded : 8);
      repeat (k) begin
        if ($urandom_range(0, 99) < 8) send_cmd(CMD_UNUSED);
        send_word(CMD_APPEND, pick_node(n), pick_node(n), pick_cost());
        loaded++;
        issued++;
      end
      if ($urandom_range(0, 99) < 85) begin
        send_cmd(CMD_RUN);
        issued++;
      end
    end
  endtask

  initial begin : receiver
    int gap;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
      if (taken == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  initial begin : sender
    logic [8:0] nc;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    cmd       = CMD_CLEAR;
    edge_from = '0;
    edge_to   = '0;
    edge_cost = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset node count, empty store
    send_cmd(CMD_RUN);
    set_node_count(9'd4);
    send_cmd(CMD_CLEAR);
    send_word(CMD_APPEND, 8'd0, 8'd1, 32'd5);
    send_word(CMD_APPEND, 8'd1, 8'd2, 32'hffff_fffd);
    send_word(CMD_APPEND, 8'd2, 8'd3, 32'h7fff_ffff);
    send_word(CMD_APPEND, 8'd3, 8'd0, 32'h8000_0000);
    send_word(CMD_APPEND, 8'd5, 8'd1, 32'hffff_ffff);
    send_word(CMD_APPEND, 8'd1, 8'd200, 32'hffff_ff00);
    send_cmd(CMD_UNUSED);
    send_cmd(CMD_RUN);
    send_cmd(CMD_CLEAR);
    // zero-weight loop, then a loop node 0 cannot reach
    send_word(CMD_APPEND, 8'd0, 8'd1, 32'd1);
    send_word(CMD_APPEND, 8'd1, 8'd0, 32'hffff_ffff);
    send_cmd(CMD_RUN);
    send_word(CMD_APPEND, 8'd2, 8'd3, 32'hffff_fff6);
    send_word(CMD_APPEND, 8'd3, 8'd2, 32'd9);
    send_word(CMD_APPEND, 8'd255, 8'd255, 32'hffff_ffff);
    send_cmd(CMD_RUN);
    set_node_count(9'd0);
    send_cmd(CMD_RUN);
    set_node_count(9'd511);
    send_cmd(CMD_RUN);
    set_node_count(9'd256);
    send_cmd(CMD_RUN);

    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        3:       nc = 9'd0;
        6:       nc = 9'($urandom_range(255, 511));
        default: nc = 9'($urandom_range(1, 16));
      endcase
      set_node_count(nc);
      random_phase(nc, 50);
    end

    set_node_count(9'd1);
    burst = 1'b0;
    send_cmd(CMD_CLEAR);
    send_word(CMD_APPEND, 8'd0, 8'd0, 32'd3);
    send_cmd(CMD_RUN);

    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE * 4) @(negedge clk);
    $display("covered %0d words and %0d runs, node counts 0 to 511,", shadow.words,
             shadow.runs);
    $display("skipped edges, saturating costs and a %0d-cycle output stall", HOLD_CYCLES);
    if (shadow.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
